### design/assert_macros.svh
// Assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/bc1_pkg.sv
package bc1_pkg;

  localparam int unsigned TexelCount = 16;
  localparam int unsigned CountWidth = 4;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;
  localparam logic [7:0]  AlphaClear  = 8'h00;
  localparam logic [9:0]  RecipThird  = 10'd683;  // 2^11 / 3, rounded up

  typedef logic [2:0][7:0] rgb_t;  // [2] red, [1] green, [0] blue

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    rgba_t [3:0] pal;
    logic [31:0] sel;
  } block_t;

  function automatic rgb_t widen565(input logic [15:0] c);
    rgb_t p;
    p[2] = {c[15:11], c[15:13]};
    p[1] = {c[10:5], c[10:9]};
    p[0] = {c[4:0], c[4:2]};
    return p;
  endfunction

  // exact floor(x / 3) for x < 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] prod;
    prod = x * RecipThird;
    return prod[18:11];
  endfunction

endpackage

### design/bc1_palette.sv
module bc1_palette (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [15:0]     endpoint_a,
  input  logic [15:0]     endpoint_b,
  input  logic [31:0]     texel_selectors,
  output logic            out_valid,
  input  logic            out_ready,
  output bc1_pkg::block_t out_block
);
  import bc1_pkg::*;

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  // stage 1: widened endpoints
  rgb_t        c0_s1, c1_s1;
  logic        four_s1;
  logic [31:0] sel_s1;

  // stage 2: channel sums
  logic [2:0][9:0] sum2_s2, sum3_s2;
  logic            four_s2;
  logic [31:0]     sel_s2;
  rgb_t            c0_s2, c1_s2;

  // stage 3: finished palette
  block_t blk_s3;

  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      c0_s1   <= widen565(endpoint_a);
      c1_s1   <= widen565(endpoint_b);
      four_s1 <= endpoint_a > endpoint_b;
      sel_s1  <= texel_selectors;
    end
    if (adv2) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum2_s2[ch] <= four_s1
                     ? ({1'b0, c0_s1[ch], 1'b0} + {2'b00, c1_s1[ch]})
                     : ({2'b00, c0_s1[ch]} + {2'b00, c1_s1[ch]});
        sum3_s2[ch] <= {2'b00, c0_s1[ch]} + {1'b0, c1_s1[ch], 1'b0};
      end
      four_s2 <= four_s1;
      sel_s2  <= sel_s1;
      c0_s2   <= c0_s1;
      c1_s2   <= c1_s1;
    end
    if (adv3) begin
      blk_s3.sel <= sel_s2;
      blk_s3.pal[0] <= '{red: c0_s2[2], green: c0_s2[1], blue: c0_s2[0], alpha: AlphaOpaque};
      blk_s3.pal[1] <= '{red: c1_s2[2], green: c1_s2[1], blue: c1_s2[0], alpha: AlphaOpaque};
      if (four_s2) begin
        blk_s3.pal[2] <= '{red: div3(sum2_s2[2]), green: div3(sum2_s2[1]),
                           blue: div3(sum2_s2[0]), alpha: AlphaOpaque};
        blk_s3.pal[3] <= '{red: div3(sum3_s2[2]), green: div3(sum3_s2[1]),
                           blue: div3(sum3_s2[0]), alpha: AlphaOpaque};
      end else begin
        blk_s3.pal[2] <= '{red: sum2_s2[2][8:1], green: sum2_s2[1][8:1],
                           blue: sum2_s2[0][8:1], alpha: AlphaOpaque};
        blk_s3.pal[3] <= '{red: AlphaClear, green: AlphaClear,
                           blue: AlphaClear, alpha: AlphaClear};
      end
    end
  end

  assign out_valid = v3;
  assign out_block = blk_s3;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_s3_hold, clk, rst, v3 && !out_ready, v3, "palette stage dropped a stalled block")
  `ASSERT_NEXT(a_s2_hold, clk, rst, v2 && !adv2, v2 && $stable(sel_s2), "stage 2 lost its block")

endmodule

### design/bc1_texel_emit.sv
module bc1_texel_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bc1_pkg::block_t in_block,
  output logic            out_valid,
  input  logic            out_ready,
  output bc1_pkg::rgba_t  out_texel,
  output logic [3:0]      out_number,
  output logic            out_last
);
  import bc1_pkg::*;

  logic                  busy;
  logic [CountWidth-1:0] count;
  block_t                blk;
  logic                  emit;
  logic                  end_of_block;

  assign emit         = busy && (!out_valid || out_ready);
  assign end_of_block = count == CountWidth'(TexelCount - 1);
  assign in_ready     = !busy || (emit && end_of_block);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (emit) begin
        busy  <= !end_of_block;
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      blk <= in_block;
    end else if (emit) begin
      blk.sel <= blk.sel >> 2;
    end
    if (emit) begin
      out_texel  <= blk.pal[blk.sel[1:0]];
      out_number <= count;
      out_last   <= end_of_block;
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_idle_count, clk, rst, busy || count == '0, "texel count running while idle")
  `ASSERT_ALWAYS(a_last_num, clk, rst, !out_valid || (out_last == (out_number == 4'hF)), "last flag off texel fifteen")
  `ASSERT_NEXT(a_load_first, clk, rst, in_valid && in_ready, busy && count == '0, "block load did not restart count")

endmodule

### design/bc1_block_decoder.sv
// Channel  | Dir | Contents
// s_axis   | in  | tdata[63:0]: endpoint_a 15:0, endpoint_b 31:16, texel_selectors 63:32
// m_axis   | out | tdata[39:0]: red, green, blue, alpha, texel_number, 4 zero bits; tlast: last_texel
//
// One block in gives sixteen texels out, one per cycle while m_axis is not stalled; the
// texel sequencer sets the sustained rate and takes the next block with its last texel.
// From block accepted to first texel valid, a block passes three palette stages, the texel
// sequencer's block register and the output register; up to four blocks are held at once.
// Synchronous active-high reset empties every stage; payload registers are not reset.
// A stall on m_axis holds the output texel and backs up through the stages to s_axis_tready.
module bc1_block_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // endpoint_a, endpoint_b, texel_selectors
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // red, green, blue, alpha, texel_number, zero pad
  output logic        m_axis_tlast
);
  import bc1_pkg::*;

  logic       pal_valid;
  logic       pal_ready;
  block_t     pal_block;
  rgba_t      texel;
  logic [3:0] number;

  bc1_palette u_palette (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .endpoint_a      (s_axis_tdata[15:0]),
    .endpoint_b      (s_axis_tdata[31:16]),
    .texel_selectors (s_axis_tdata[63:32]),
    .out_valid       (pal_valid),
    .out_ready       (pal_ready),
    .out_block       (pal_block)
  );

  bc1_texel_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pal_valid),
    .in_ready   (pal_ready),
    .in_block   (pal_block),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_texel  (texel),
    .out_number (number),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, number, texel.alpha, texel.blue, texel.green, texel.red};

`include "assert_macros.svh"

  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled texel changed")

endmodule
